### rtl/core/wse3_pkg.sv
`timescale 1ns / 1ps

package wse3_pkg;

    typedef logic [7:0]  t_element;
    typedef logic [11:0] t_sum;
    typedef logic [4:0]  t_place;
    typedef logic [5:0]  t_cfg_count;
    typedef logic [0:0]  t_cfg_index;

    localparam t_cfg_index CFG_ROW_COUNT    = 1'b0;
    localparam t_cfg_index CFG_COLUMN_COUNT = 1'b1;

    localparam t_cfg_count CFG_COUNT_RESET  = 6'd32;

endpackage

### rtl/core/wse3_in_if.sv
`timescale 1ns / 1ps

interface wse3_in_if;
    import wse3_pkg::*;

    logic     valid;
    logic     ready;
    t_element element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

### rtl/core/wse3_out_if.sv
`timescale 1ns / 1ps

interface wse3_out_if;
    import wse3_pkg::*;

    logic   valid;
    logic   ready;
    t_sum   largest_sum;
    t_place largest_row;
    t_place largest_column;
    t_sum   smallest_sum;
    t_place smallest_row;
    t_place smallest_column;
    logic   no_window;

    modport source (
        output valid, input ready,
        output largest_sum, output largest_row, output largest_column,
        output smallest_sum, output smallest_row, output smallest_column,
        output no_window
    );
    modport sink (
        input valid, output ready,
        input largest_sum, input largest_row, input largest_column,
        input smallest_sum, input smallest_row, input smallest_column,
        input no_window
    );
endinterface

### rtl/core/window_sum_extrema_3x3.sv
`timescale 1ns / 1ps

// Streams a matrix in raster order, one element per item, and after the last
// element of a frame returns one item with the largest and the smallest 3x3
// window sum and the top-left row and column of each (first window in raster
// order wins a tie). Frame size comes from row_count (index 0) and
// column_count (index 1); write them only while the block is idle. A count of
// 0 acts as 1 and a count above MAX_ROWS / MAX_COLUMNS saturates. Matrices
// smaller than 3x3 report no_window with all other fields zero. The block
// takes one element per clock: the two previous rows live in one synchronous
// line store (one entry per column) that is read when an element is accepted
// and written back as that element leaves the sum stage, with a bypass when the
// same column is read in the write cycle. The result is registered as the last
// element leaves the sum stage. Input is held off only while a result waits on
// the output and the last element of the next frame has reached the sum stage.
module window_sum_extrema_3x3 #(
    parameter int MAX_ROWS     = 32,
    parameter int MAX_COLUMNS  = 32,
    parameter int ELEMENT_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  wse3_pkg::t_cfg_index i_cfg_index,
    input  wse3_pkg::t_cfg_count i_cfg_data,
    wse3_in_if.sink              i_elem,
    wse3_out_if.source           o_result
);
    import wse3_pkg::*;

    localparam int EW  = ELEMENT_BITS;
    localparam int CSW = EW + 2;          // three elements
    localparam int SW  = EW + 4;          // nine elements
    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int RW  = $clog2(MAX_ROWS);

    function automatic logic [CW-1:0] last_col_of(input t_cfg_count v);
        if (v == '0)                 return '0;
        else if (v > MAX_COLUMNS)    return CW'(MAX_COLUMNS - 1);
        else                         return CW'(v - 6'd1);
    endfunction

    function automatic logic [RW-1:0] last_row_of(input t_cfg_count v);
        if (v == '0)                 return '0;
        else if (v > MAX_ROWS)       return RW'(MAX_ROWS - 1);
        else                         return RW'(v - 6'd1);
    endfunction

    // configuration
    t_cfg_count r_cfg_rows;
    t_cfg_count r_cfg_cols;

    // accept stage
    logic [CW-1:0] r_col_pos;
    logic [RW-1:0] r_row_pos;
    logic [CW-1:0] last_col;
    logic [RW-1:0] last_row;
    logic          row_end;
    logic          frame_end;
    logic          in_acc;
    logic          in_rdy;

    // line store: {older, newer} per column
    logic [2*EW-1:0] mem [MAX_COLUMNS];
    logic [2*EW-1:0] r_rd;
    logic [2*EW-1:0] wdata;

    // sum stage
    logic          r_b_valid;
    logic [EW-1:0] r_b_x;
    logic [CW-1:0] r_b_col;
    logic [RW-1:0] r_b_row;
    logic          r_b_frame_end;
    logic          r_b_small;
    logic          b_adv;

    logic [CSW-1:0] r_cs_left;
    logic [CSW-1:0] r_cs_mid;
    logic [SW-1:0]  r_high_sum;
    logic [RW-1:0]  r_high_row;
    logic [CW-1:0]  r_high_col;
    logic [SW-1:0]  r_low_sum;
    logic [RW-1:0]  r_low_row;
    logic [CW-1:0]  r_low_col;

    logic [CSW-1:0] col_sum;
    logic [SW-1:0]  win;
    logic           has_win;
    logic [SW-1:0]  n_high_sum;
    logic [RW-1:0]  n_high_row;
    logic [CW-1:0]  n_high_col;
    logic [SW-1:0]  n_low_sum;
    logic [RW-1:0]  n_low_row;
    logic [CW-1:0]  n_low_col;

    // result register
    logic   r_o_valid;
    t_sum   r_o_high_sum;
    t_place r_o_high_row;
    t_place r_o_high_col;
    t_sum   r_o_low_sum;
    t_place r_o_low_row;
    t_place r_o_low_col;
    logic   r_o_no_window;
    logic   o_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows <= CFG_COUNT_RESET;
            r_cfg_cols <= CFG_COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ROW_COUNT:    r_cfg_rows <= i_cfg_data;
                CFG_COLUMN_COUNT: r_cfg_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign last_col  = last_col_of(r_cfg_cols);
    assign last_row  = last_row_of(r_cfg_rows);
    assign row_end   = (r_col_pos >= last_col);
    assign frame_end = row_end && (r_row_pos >= last_row);

    // a frame-end item may only leave the sum stage into a free result slot
    assign b_adv  = r_b_valid && !(r_b_frame_end && r_o_valid && !o_result.ready);
    assign in_rdy = !r_b_valid || b_adv;
    assign in_acc = i_elem.valid && in_rdy;
    assign i_elem.ready = in_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                if (frame_end) begin
                    r_col_pos <= '0;
                    r_row_pos <= '0;
                end else if (row_end) begin
                    r_col_pos <= '0;
                    r_row_pos <= r_row_pos + RW'(1);
                end else begin
                    r_col_pos <= r_col_pos + CW'(1);
                end
            end
            if (in_acc)
                r_b_valid <= 1'b1;
            else if (b_adv)
                r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_x         <= EW'(i_elem.element_value);
            r_b_col       <= r_col_pos;
            r_b_row       <= r_row_pos;
            r_b_frame_end <= frame_end;
            r_b_small     <= (last_row < RW'(2)) || (last_col < CW'(2));
        end
    end

    // shift the column down one row: older takes newer, newer takes the item
    assign wdata = {r_rd[EW-1:0], r_b_x};

    always_ff @(posedge i_clk) begin
        if (b_adv)
            mem[r_b_col] <= wdata;
        if (in_acc) begin
            if (b_adv && (r_b_col == r_col_pos))
                r_rd <= wdata;
            else
                r_rd <= mem[r_col_pos];
        end
    end

    always_comb begin
        col_sum = CSW'(r_rd[2*EW-1:EW]) + CSW'(r_rd[EW-1:0]) + CSW'(r_b_x);
        win     = SW'(r_cs_left) + SW'(r_cs_mid) + SW'(col_sum);
        has_win = (r_b_row >= RW'(2)) && (r_b_col >= CW'(2));

        n_high_sum = r_high_sum;
        n_high_row = r_high_row;
        n_high_col = r_high_col;
        n_low_sum  = r_low_sum;
        n_low_row  = r_low_row;
        n_low_col  = r_low_col;
        if (has_win && (win > r_high_sum)) begin
            n_high_sum = win;
            n_high_row = r_b_row - RW'(2);
            n_high_col = r_b_col - CW'(2);
        end
        if (has_win && (win < r_low_sum)) begin
            n_low_sum = win;
            n_low_row = r_b_row - RW'(2);
            n_low_col = r_b_col - CW'(2);
        end
    end

    assign o_load = b_adv && r_b_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs_left  <= '0;
            r_cs_mid   <= '0;
            r_high_sum <= '0;
            r_high_row <= '0;
            r_high_col <= '0;
            r_low_sum  <= '1;
            r_low_row  <= '0;
            r_low_col  <= '0;
        end else if (o_load) begin
            // restart the frame
            r_cs_left  <= '0;
            r_cs_mid   <= '0;
            r_high_sum <= '0;
            r_high_row <= '0;
            r_high_col <= '0;
            r_low_sum  <= '1;
            r_low_row  <= '0;
            r_low_col  <= '0;
        end else if (b_adv) begin
            r_cs_left  <= r_cs_mid;
            r_cs_mid   <= col_sum;
            r_high_sum <= n_high_sum;
            r_high_row <= n_high_row;
            r_high_col <= n_high_col;
            r_low_sum  <= n_low_sum;
            r_low_row  <= n_low_row;
            r_low_col  <= n_low_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_o_valid <= 1'b0;
        else if (o_load)
            r_o_valid <= 1'b1;
        else if (o_result.ready)
            r_o_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_o_no_window <= r_b_small;
            if (r_b_small) begin
                r_o_high_sum <= '0;
                r_o_high_row <= '0;
                r_o_high_col <= '0;
                r_o_low_sum  <= '0;
                r_o_low_row  <= '0;
                r_o_low_col  <= '0;
            end else begin
                r_o_high_sum <= 12'(n_high_sum);
                r_o_high_row <= 5'(n_high_row);
                r_o_high_col <= 5'(n_high_col);
                r_o_low_sum  <= 12'(n_low_sum);
                r_o_low_row  <= 5'(n_low_row);
                r_o_low_col  <= 5'(n_low_col);
            end
        end
    end

    assign o_result.valid           = r_o_valid;
    assign o_result.largest_sum     = r_o_high_sum;
    assign o_result.largest_row     = r_o_high_row;
    assign o_result.largest_column  = r_o_high_col;
    assign o_result.smallest_sum    = r_o_low_sum;
    assign o_result.smallest_row    = r_o_low_row;
    assign o_result.smallest_column = r_o_low_col;
    assign o_result.no_window       = r_o_no_window;

`ifndef SYNTHESIS
    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_adv && in_acc && (r_b_col == r_col_pos)) |=> (r_rd == $past(wdata)))
        else $error("line store bypass lost the written column");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(b_adv && r_b_frame_end))
        else $error("result raised without a frame end");

    a_extrema_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_load && !r_b_small) |-> (n_low_sum <= n_high_sum))
        else $error("smallest window sum above largest");

    a_no_window_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_no_window) |->
            (r_o_high_sum == '0) && (r_o_low_sum == '0) &&
            (r_o_high_row == '0) && (r_o_low_col == '0))
        else $error("no-window result carries nonzero fields");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_result.ready) |=> !$rose(r_o_no_window) || $past(o_load))
        else $error("held result overwritten");
`endif

endmodule
